/* design/enq_pkg.sv */
package enq_pkg;

    localparam int SOCKETS_DEF     = 256;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int CMD_FIFO_DEPTH  = 2;
    localparam int MAX_OUT         = 64;

    localparam logic [5:0] ALWAYS_BITS = 6'h18;

    typedef enum logic [2:0] {
        KIND_REGISTER = 3'd0,
        KIND_MODIFY   = 3'd1,
        KIND_DELETE   = 3'd2,
        KIND_POST_USR = 3'd3,
        KIND_POST_SHD = 3'd4,
        KIND_FETCH    = 3'd5,
        KIND_IN_USE   = 3'd6,
        KIND_NONE     = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_ALREADY  = 3'd1,
        STATUS_NOT_REG  = 3'd2,
        STATUS_EMPTY    = 3'd3,
        STATUS_FULL     = 3'd4,
        STATUS_UNUSED5  = 3'd5,
        STATUS_UNUSED6  = 3'd6,
        STATUS_UNUSED7  = 3'd7
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  socket;
        logic        in_range;
        logic [5:0]  event_mask;
        logic [63:0] user_data;
        logic [6:0]  limit;
        logic        in_use;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        has_event;
        logic [7:0]  fired_socket;
        logic [5:0]  event_bits;
        logic [63:0] event_data;
        logic        last;
    } result_t;

    typedef struct packed {
        logic        live;
        logic [5:0]  interest;
        logic [5:0]  pending;
        logic [63:0] data;
    } sock_word_t;

endpackage

/* design/enq_in_if.sv */
interface enq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  socket;
    logic [5:0]  event_mask;
    logic [63:0] user_data;
    logic [6:0]  max_events;
    logic        in_use;

    modport source (output valid, kind, socket, event_mask, user_data, max_events, in_use,
                    input ready);
    modport sink (input valid, kind, socket, event_mask, user_data, max_events, in_use,
                  output ready);
endinterface

/* design/enq_out_if.sv */
interface enq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        has_event;
    logic [7:0]  fired_socket;
    logic [5:0]  event_bits;
    logic [63:0] event_data;
    logic        last;

    modport source (output valid, status, has_event, fired_socket, event_bits, event_data,
                    last, input ready);
    modport sink (input valid, status, has_event, fired_socket, event_bits, event_data,
                  last, output ready);
endinterface

/* design/enq_front.sv */
module enq_front #(
    parameter int SOCKETS = enq_pkg::SOCKETS_DEF
) (
    enq_in_if.sink        cmd,
    input  logic          fifo_full,
    input  logic          clear_done,
    output logic          push,
    output enq_pkg::cmd_t push_cmd
);

    always_comb
    begin
        cmd.ready         = clear_done && !fifo_full;
        push              = cmd.valid && cmd.ready;
        push_cmd.kind     = enq_pkg::kind_t'(cmd.kind);
        push_cmd.socket   = cmd.socket;
        push_cmd.in_range = (32'(cmd.socket) < SOCKETS);
        push_cmd.event_mask = cmd.event_mask;
        push_cmd.user_data  = cmd.user_data;
        // limit saturates at the largest fetch
        push_cmd.limit    = (cmd.max_events > 7'(enq_pkg::MAX_OUT)) ?
                            7'(enq_pkg::MAX_OUT) : cmd.max_events;
        push_cmd.in_use   = cmd.in_use;
    end

endmodule

/* design/enq_fifo.sv */
module enq_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  enq_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output enq_pkg::cmd_t head_cmd
);

    localparam int D  = enq_pkg::CMD_FIFO_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    enq_pkg::cmd_t  entry_reg [D];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full      = (count_reg == CW'(D));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(D - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(D - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* design/enq_back.sv */
module enq_back #(
    parameter int SOCKETS     = enq_pkg::SOCKETS_DEF,
    parameter int QUEUE_DEPTH = enq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fifo_not_empty,
    input  enq_pkg::cmd_t fifo_cmd,
    output logic          pop,
    output logic          clear_done,
    enq_out_if.source     evt
);

    localparam int SW = $clog2(SOCKETS);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int EW = 14 + 64;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_EXEC  = 7'b0000100,
        ST_FQ    = 7'b0001000,
        ST_FS    = 7'b0010000,
        ST_FX    = 7'b0100000,
        ST_FEND  = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [SW-1:0]        clr_reg, clr_next;
    enq_pkg::cmd_t        cmd_reg, cmd_next;
    logic [6:0]           cnt_reg, cnt_next;
    logic                 hold_valid_reg, hold_valid_next;
    enq_pkg::result_t     hold_reg, hold_next;
    enq_pkg::result_t     out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 qsel_reg, qsel_next;
    logic [QW-1:0]        uhead_reg, uhead_next, utail_reg, utail_next;
    logic [QW-1:0]        shead_reg, shead_next, stail_reg, stail_next;
    logic [QW:0]          ucount_reg, ucount_next, scount_reg, scount_next;

    enq_pkg::sock_word_t  sock_mem [SOCKETS];
    enq_pkg::sock_word_t  sock_rd_reg;
    logic [EW-1:0]        uq_mem [QUEUE_DEPTH];
    logic [EW-1:0]        sq_mem [QUEUE_DEPTH];
    logic [EW-1:0]        q_rd_reg;

    logic                 sock_we, sock_re;
    logic [SW-1:0]        sock_wa, sock_ra;
    enq_pkg::sock_word_t  sock_wd, w;
    logic                 uq_we, sq_we, q_re;
    logic [EW-1:0]        q_wd;
    logic                 out_free, ok;
    logic [SW+7:0]        fifo_sock_ext, q_sock_ext, cmd_sock_ext;
    logic [5:0]           q_bits;
    logic [QW:0]          post_count;

    assign out_free      = !out_valid_reg || evt.ready;
    assign clear_done    = (state_reg != ST_CLEAR);
    assign fifo_sock_ext = {{SW{1'b0}}, fifo_cmd.socket};
    assign q_sock_ext    = {{SW{1'b0}}, q_rd_reg[EW-1:EW-8]};
    assign cmd_sock_ext  = {{SW{1'b0}}, cmd_reg.socket};
    assign q_bits        = q_rd_reg[EW-9:64];
    assign post_count    = (cmd_reg.kind == enq_pkg::KIND_POST_USR) ? ucount_reg : scount_reg;

    assign evt.valid        = out_valid_reg;
    assign evt.status       = out_reg.status;
    assign evt.has_event    = out_reg.has_event;
    assign evt.fired_socket = out_reg.fired_socket;
    assign evt.event_bits   = out_reg.event_bits;
    assign evt.event_data   = out_reg.event_data;
    assign evt.last         = out_reg.last;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cmd_next        = cmd_reg;
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !evt.ready;
        qsel_next       = qsel_reg;
        uhead_next      = uhead_reg;
        utail_next      = utail_reg;
        ucount_next     = ucount_reg;
        shead_next      = shead_reg;
        stail_next      = stail_reg;
        scount_next     = scount_reg;
        pop     = 1'b0;
        sock_we = 1'b0;
        sock_wa = '0;
        sock_wd = '0;
        sock_re = 1'b0;
        sock_ra = fifo_sock_ext[SW-1:0];
        uq_we   = 1'b0;
        sq_we   = 1'b0;
        q_wd    = '0;
        q_re    = 1'b0;
        w       = sock_rd_reg;
        ok      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                sock_we  = 1'b1;
                sock_wa  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SW'(SOCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (fifo_not_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = fifo_cmd;
                    if (fifo_cmd.kind == enq_pkg::KIND_FETCH)
                    begin
                        cnt_next        = '0;
                        hold_valid_next = 1'b0;
                        state_next      = ST_FQ;
                    end
                    else
                    begin
                        sock_re    = 1'b1;
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.last  = 1'b1;
                    out_next.status = enq_pkg::STATUS_OK;
                    sock_wa = cmd_sock_ext[SW-1:0];
                    state_next = ST_IDLE;
                    if (!cmd_reg.in_range && cmd_reg.kind != enq_pkg::KIND_NONE)
                    begin
                        out_next.status = enq_pkg::STATUS_NOT_REG;
                    end
                    else
                    begin
                        case (cmd_reg.kind)
                            enq_pkg::KIND_REGISTER:
                            begin
                                if (sock_rd_reg.interest != '0)
                                begin
                                    out_next.status = enq_pkg::STATUS_ALREADY;
                                end
                                else
                                begin
                                    w.interest = cmd_reg.event_mask | enq_pkg::ALWAYS_BITS;
                                    w.data     = cmd_reg.user_data;
                                    sock_we    = 1'b1;
                                end
                            end
                            enq_pkg::KIND_MODIFY:
                            begin
                                if (sock_rd_reg.interest == '0)
                                begin
                                    out_next.status = enq_pkg::STATUS_NOT_REG;
                                end
                                else
                                begin
                                    w.interest = cmd_reg.event_mask | enq_pkg::ALWAYS_BITS;
                                    w.data     = cmd_reg.user_data;
                                    sock_we    = 1'b1;
                                end
                            end
                            enq_pkg::KIND_DELETE:
                            begin
                                if (sock_rd_reg.interest == '0)
                                begin
                                    out_next.status = enq_pkg::STATUS_NOT_REG;
                                end
                                else
                                begin
                                    w.interest = '0;
                                    sock_we    = 1'b1;
                                end
                            end
                            enq_pkg::KIND_POST_USR, enq_pkg::KIND_POST_SHD:
                            begin
                                if (cmd_reg.event_mask == '0)
                                begin
                                    out_next.status = enq_pkg::STATUS_EMPTY;
                                end
                                else if ((sock_rd_reg.pending & cmd_reg.event_mask) != '0)
                                begin
                                    out_next.status = enq_pkg::STATUS_OK;
                                end
                                else if (post_count >= (QW+1)'(QUEUE_DEPTH))
                                begin
                                    out_next.status = enq_pkg::STATUS_FULL;
                                end
                                else
                                begin
                                    w.pending = sock_rd_reg.pending | cmd_reg.event_mask;
                                    sock_we   = 1'b1;
                                    q_wd = {cmd_reg.socket, cmd_reg.event_mask,
                                            sock_rd_reg.data};
                                    if (cmd_reg.kind == enq_pkg::KIND_POST_USR)
                                    begin
                                        uq_we       = 1'b1;
                                        utail_next  = (utail_reg == QW'(QUEUE_DEPTH - 1)) ?
                                                      '0 : utail_reg + 1'b1;
                                        ucount_next = ucount_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        sq_we       = 1'b1;
                                        stail_next  = (stail_reg == QW'(QUEUE_DEPTH - 1)) ?
                                                      '0 : stail_reg + 1'b1;
                                        scount_next = scount_reg + 1'b1;
                                    end
                                end
                            end
                            enq_pkg::KIND_IN_USE:
                            begin
                                w.live  = cmd_reg.in_use;
                                sock_we = 1'b1;
                            end
                            default:
                            begin
                                out_next.status = enq_pkg::STATUS_OK;
                            end
                        endcase
                    end
                    sock_wd = w;
                end
            end
            ST_FQ:
            begin
                if (cnt_reg < cmd_reg.limit && ucount_reg != '0)
                begin
                    q_re        = 1'b1;
                    qsel_next   = 1'b0;
                    uhead_next  = (uhead_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : uhead_reg + 1'b1;
                    ucount_next = ucount_reg - 1'b1;
                    state_next  = ST_FS;
                end
                else if (cnt_reg < cmd_reg.limit && scount_reg != '0)
                begin
                    q_re        = 1'b1;
                    qsel_next   = 1'b1;
                    shead_next  = (shead_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : shead_reg + 1'b1;
                    scount_next = scount_reg - 1'b1;
                    state_next  = ST_FS;
                end
                else
                begin
                    state_next = ST_FEND;
                end
            end
            ST_FS:
            begin
                sock_re    = 1'b1;
                sock_ra    = q_sock_ext[SW-1:0];
                state_next = ST_FX;
            end
            ST_FX:
            begin
                ok = sock_rd_reg.live && ((sock_rd_reg.interest & q_bits) != '0) &&
                     ((sock_rd_reg.pending & q_bits) != '0);
                if (!(ok && hold_valid_reg && !out_free))
                begin
                    sock_we   = 1'b1;
                    sock_wa   = q_sock_ext[SW-1:0];
                    w.pending = sock_rd_reg.pending & ~q_bits;
                    sock_wd   = w;
                    if (ok)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = hold_reg;
                            out_next.last  = 1'b0;
                        end
                        hold_valid_next        = 1'b1;
                        hold_next.status       = enq_pkg::STATUS_OK;
                        hold_next.has_event    = 1'b1;
                        hold_next.fired_socket = q_rd_reg[EW-1:EW-8];
                        hold_next.event_bits   = q_bits;
                        hold_next.event_data   = q_rd_reg[63:0];
                        hold_next.last         = 1'b0;
                    end
                    state_next = ST_FQ;
                end
            end
            ST_FEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (hold_valid_reg)
                    begin
                        out_next = hold_reg;
                    end
                    else
                    begin
                        out_next = '0;
                    end
                    out_next.last   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            qsel_reg       <= 1'b0;
            uhead_reg      <= '0;
            utail_reg      <= '0;
            ucount_reg     <= '0;
            shead_reg      <= '0;
            stail_reg      <= '0;
            scount_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            qsel_reg       <= qsel_next;
            uhead_reg      <= uhead_next;
            utail_reg      <= utail_next;
            ucount_reg     <= ucount_next;
            shead_reg      <= shead_next;
            stail_reg      <= stail_next;
            scount_reg     <= scount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (sock_we)
        begin
            sock_mem[sock_wa] <= sock_wd;
        end
        if (sock_re)
        begin
            sock_rd_reg <= sock_mem[sock_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (uq_we)
        begin
            uq_mem[utail_reg] <= q_wd;
        end
        if (sq_we)
        begin
            sq_mem[stail_reg] <= q_wd;
        end
        if (q_re)
        begin
            q_rd_reg <= (qsel_next) ? sq_mem[shead_reg] : uq_mem[uhead_reg];
        end
    end

endmodule

/* design/event_notify_queue_top.sv */
// channel | dir | handshake           | payload
// cmd     | in  | cmd.valid/cmd.ready | kind socket event_mask user_data max_events in_use
// evt     | out | evt.valid/evt.ready | status has_event fired_socket event_bits event_data last
//
// a non-fetch command reads the socket table, then does one read-modify-write
// a fetch takes each queue entry through a queue read, a socket table read and a pending-bit clear
// after reset a clearing pass writes every socket table entry; cmd.ready stays low during it
// a 2-deep command queue separates intake from execution; evt has its own output register
// the back end waits to write a result while one is held in the output register and evt.ready is low
module event_notify_queue_top #(
    parameter int SOCKETS     = enq_pkg::SOCKETS_DEF,
    parameter int QUEUE_DEPTH = enq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    enq_in_if.sink    cmd,
    enq_out_if.source evt
);

    logic          push, pop, fifo_full, fifo_not_empty, clear_done;
    enq_pkg::cmd_t push_cmd, head_cmd;

    enq_front #(
        .SOCKETS (SOCKETS)
    ) u_front (
        .cmd        (cmd),
        .fifo_full  (fifo_full),
        .clear_done (clear_done),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    enq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (fifo_full),
        .not_empty (fifo_not_empty),
        .head_cmd  (head_cmd)
    );

    enq_back #(
        .SOCKETS     (SOCKETS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .fifo_not_empty (fifo_not_empty),
        .fifo_cmd       (head_cmd),
        .pop            (pop),
        .clear_done     (clear_done),
        .evt            (evt)
    );

endmodule

/* sim/tb_event_notify_queue_top.sv */
`timescale 1ns / 100ps

module tb_event_notify_queue_top;

    localparam int NSOCK = enq_pkg::SOCKETS_DEF;
    localparam int QDEPTH = enq_pkg::QUEUE_DEPTH_DEF;

    typedef struct {
        logic [2:0]  status;
        logic        has_event;
        logic [7:0]  fired_socket;
        logic [5:0]  event_bits;
        logic [63:0] event_data;
        logic        last;
    } evt_item_t;

    typedef struct {
        enq_pkg::kind_t   kind;
        logic [7:0]       socket;
        logic [5:0]       event_mask;
        logic [63:0]      user_data;
        logic [6:0]       max_events;
        logic             in_use;
        logic             typed;
        enq_pkg::status_t want_status;
    } cmd_row_t;

    typedef struct {
        logic [13:0] tag;
        logic [63:0] data;
    } ring_entry_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    bit   quiet;

    enq_in_if  cmd();
    enq_out_if evt();

    event_notify_queue_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .evt   (evt.source)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    logic [5:0]  interest [NSOCK];
    logic [5:0]  pending [NSOCK];
    logic [63:0] sock_data [NSOCK];
    logic        live [NSOCK];
    ring_entry_t user_ring [$];
    ring_entry_t shadow_ring [$];
    evt_item_t   expected_events [$];

    function automatic evt_item_t plain_status(logic [2:0] st);
        evt_item_t r;
        r = '{st, 1'b0, 8'd0, 6'd0, 64'd0, 1'b1};
        return r;
    endfunction

    function automatic logic [2:0] queue_event(bit to_user, int s, logic [5:0] bits);
        ring_entry_t e;
        if (bits == 6'd0)
            return enq_pkg::STATUS_EMPTY;
        if ((pending[s] & bits) != 6'd0)
            return enq_pkg::STATUS_OK;
        if ((to_user ? user_ring.size() : shadow_ring.size()) >= QDEPTH)
            return enq_pkg::STATUS_FULL;
        pending[s] = pending[s] | bits;
        e.tag = {s[7:0], bits};
        e.data = sock_data[s];
        if (to_user)
            user_ring.push_back(e);
        else
            shadow_ring.push_back(e);
        return enq_pkg::STATUS_OK;
    endfunction

    task automatic drain_ring(bit from_user, int limit, inout int cnt);
        ring_entry_t e;
        int s;
        logic [5:0] b;
        evt_item_t r;
        while ((from_user ? user_ring.size() : shadow_ring.size()) > 0 && cnt < limit)
        begin
            e = from_user ? user_ring.pop_front() : shadow_ring.pop_front();
            s = e.tag[13:6];
            b = e.tag[5:0];
            if (live[s] && (interest[s] & b) != 0 && (pending[s] & b) != 0)
            begin
                r = '{enq_pkg::STATUS_OK, 1'b1, s[7:0], b, e.data, 1'b0};
                expected_events.push_back(r);
                cnt++;
            end
            pending[s] = pending[s] & ~b;
        end
    endtask

    task automatic predict_events(cmd_row_t c);
        int s;
        int limit;
        int cnt;
        logic [2:0] st;
        s = c.socket;
        st = enq_pkg::STATUS_OK;
        if (c.kind == enq_pkg::KIND_FETCH)
        begin
            limit = c.max_events > enq_pkg::MAX_OUT ? enq_pkg::MAX_OUT : c.max_events;
            cnt = 0;
            drain_ring(1'b1, limit, cnt);
            drain_ring(1'b0, limit, cnt);
            if (cnt == 0)
                expected_events.push_back(plain_status(enq_pkg::STATUS_OK));
            else
                expected_events[$].last = 1'b1;
            return;
        end
        if (s >= NSOCK && c.kind != enq_pkg::KIND_NONE)
            st = enq_pkg::STATUS_NOT_REG;
        else
        begin
            case (c.kind)
                enq_pkg::KIND_REGISTER:
                    if (interest[s] != 0)
                        st = enq_pkg::STATUS_ALREADY;
                    else
                    begin
                        interest[s] = c.event_mask | enq_pkg::ALWAYS_BITS;
                        sock_data[s] = c.user_data;
                    end
                enq_pkg::KIND_MODIFY:
                    if (interest[s] == 0)
                        st = enq_pkg::STATUS_NOT_REG;
                    else
                    begin
                        interest[s] = c.event_mask | enq_pkg::ALWAYS_BITS;
                        sock_data[s] = c.user_data;
                    end
                enq_pkg::KIND_DELETE:
                    if (interest[s] == 0)
                        st = enq_pkg::STATUS_NOT_REG;
                    else
                        interest[s] = 6'd0;
                enq_pkg::KIND_POST_USR: st = queue_event(1'b1, s, c.event_mask);
                enq_pkg::KIND_POST_SHD: st = queue_event(1'b0, s, c.event_mask);
                enq_pkg::KIND_IN_USE:   live[s] = c.in_use;
                default: ;
            endcase
        end
        expected_events.push_back(plain_status(st));
    endtask

    task automatic idle_burst(input logic is_cmd);
        int n;
        n = $urandom_range(12, 1);
        if (is_cmd)
            cmd.valid <= 1'b0;
        else
            evt.ready <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic send_cmd(cmd_row_t c);
        if (!quiet && $urandom_range(7, 0) == 0)
            idle_burst(1'b1);
        cmd.valid      <= 1'b1;
        cmd.kind       <= c.kind;
        cmd.socket     <= c.socket;
        cmd.event_mask <= c.event_mask;
        cmd.user_data  <= c.user_data;
        cmd.max_events <= c.max_events;
        cmd.in_use     <= c.in_use;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        predict_events(c);
        if (c.typed && expected_events[$].status != c.want_status)
        begin
            $error("table status: expected %0d, actual %0d", c.want_status,
                   expected_events[$].status);
            fail_count++;
        end
        @(negedge clk);
    endtask

    function automatic cmd_row_t make_row(enq_pkg::kind_t k, int s, int m, logic [63:0] d,
                                          int mx, bit u, bit typed, enq_pkg::status_t ws);
        cmd_row_t c;
        c = '{k, s[7:0], m[5:0], d, mx[6:0], u, typed, ws};
        return c;
    endfunction

    function automatic cmd_row_t random_row();
        int pick;
        enq_pkg::kind_t k;
        pick = $urandom_range(99, 0);
        if (pick < 12)      k = enq_pkg::KIND_REGISTER;
        else if (pick < 20) k = enq_pkg::KIND_MODIFY;
        else if (pick < 26) k = enq_pkg::KIND_DELETE;
        else if (pick < 50) k = enq_pkg::KIND_POST_USR;
        else if (pick < 66) k = enq_pkg::KIND_POST_SHD;
        else if (pick < 80) k = enq_pkg::KIND_FETCH;
        else if (pick < 96) k = enq_pkg::KIND_IN_USE;
        else                k = enq_pkg::KIND_NONE;
        return make_row(k, $urandom_range(99, 0) < 85 ? $urandom_range(7, 0)
                                                       : $urandom_range(255, 0),
                        $urandom_range(63, 0), {$urandom, $urandom},
                        $urandom_range(127, 0), $urandom_range(99, 0) < 80, 1'b0,
                        enq_pkg::STATUS_OK);
    endfunction

    always @(posedge clk)
    begin
        evt_item_t want;
        if (rst_n && evt.valid && evt.ready)
        begin
            if (expected_events.size() == 0)
            begin
                $error("event with nothing expected: status %0d socket %0d",
                       evt.status, evt.fired_socket);
                fail_count++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (evt.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, evt.status);
                    fail_count++;
                end
                if (evt.has_event !== want.has_event)
                begin
                    $error("has_event: expected %0d, actual %0d", want.has_event,
                           evt.has_event);
                    fail_count++;
                end
                if (evt.fired_socket !== want.fired_socket)
                begin
                    $error("fired_socket: expected %0d, actual %0d", want.fired_socket,
                           evt.fired_socket);
                    fail_count++;
                end
                if (evt.event_bits !== want.event_bits)
                begin
                    $error("event_bits: expected %h, actual %h", want.event_bits,
                           evt.event_bits);
                    fail_count++;
                end
                if (evt.event_data !== want.event_data)
                begin
                    $error("event_data: expected %h, actual %h", want.event_data,
                           evt.event_data);
                    fail_count++;
                end
                if (evt.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, evt.last);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        @(negedge clk);
        while (1)
        begin
            if (!quiet && $urandom_range(5, 0) == 0)
                idle_burst(1'b0);
            evt.ready <= 1'b1;
            @(negedge clk);
        end
    end

    initial
    begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        cmd_row_t dir_rows [$];
        cmd_row_t r;
        int wait_cycles;
        fail_count = 0;
        quiet = 1'b0;
        for (int i = 0; i < NSOCK; i++)
        begin
            interest[i] = '0;
            pending[i] = '0;
            sock_data[i] = '0;
            live[i] = 1'b0;
        end
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.kind = enq_pkg::KIND_NONE;
        cmd.socket = '0;
        cmd.event_mask = '0;
        cmd.user_data = '0;
        cmd.max_events = '0;
        cmd.in_use = 1'b0;
        evt.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        dir_rows.push_back(make_row(enq_pkg::KIND_FETCH, 0, 0, 0, 1, 0, 1,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_MODIFY, 255, 63, 0, 1, 0, 1,
                                    enq_pkg::STATUS_NOT_REG));
        dir_rows.push_back(make_row(enq_pkg::KIND_DELETE, 3, 0, 0, 1, 0, 1,
                                    enq_pkg::STATUS_NOT_REG));
        dir_rows.push_back(make_row(enq_pkg::KIND_REGISTER, 0, 0, '1, 1, 0, 1,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_REGISTER, 255, 63, 64'h5a5a_0000_ffff_1234,
                                    1, 0, 1, enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_REGISTER, 0, 7, 0, 1, 0, 1,
                                    enq_pkg::STATUS_ALREADY));
        dir_rows.push_back(make_row(enq_pkg::KIND_IN_USE, 0, 0, 0, 1, 1, 1,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_IN_USE, 255, 0, 0, 1, 1, 1,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_POST_USR, 0, 0, 0, 1, 0, 1,
                                    enq_pkg::STATUS_EMPTY));
        dir_rows.push_back(make_row(enq_pkg::KIND_POST_USR, 0, 8, 0, 1, 0, 1,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_POST_USR, 0, 8, 0, 1, 0, 1,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_POST_SHD, 255, 63, 0, 1, 0, 1,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_POST_SHD, 7, 1, 0, 1, 0, 1,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_FETCH, 0, 0, 0, 127, 0, 0,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_MODIFY, 255, 1, '0, 1, 0, 1,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_POST_USR, 255, 2, 0, 1, 0, 1,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_DELETE, 255, 0, 0, 1, 0, 1,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_FETCH, 0, 0, 0, 0, 0, 0,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_FETCH, 0, 0, 0, 64, 0, 0,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_NONE, 9, 5, 0, 3, 1, 1,
                                    enq_pkg::STATUS_OK));
        dir_rows.push_back(make_row(enq_pkg::KIND_IN_USE, 0, 0, 0, 1, 0, 1,
                                    enq_pkg::STATUS_OK));
        foreach (dir_rows[i])
            send_cmd(dir_rows[i]);

        // fill the user ring to overflow
        send_cmd(make_row(enq_pkg::KIND_REGISTER, 1, 63, 64'h1, 1, 0, 0, enq_pkg::STATUS_OK));
        send_cmd(make_row(enq_pkg::KIND_IN_USE, 1, 0, 0, 1, 1, 0, enq_pkg::STATUS_OK));
        for (int i = 0; i < QDEPTH + 1; i++)
        begin
            r = make_row(enq_pkg::KIND_POST_USR, 8 + (i % 40), 1 << (i / 40), 0, 1, 0, 0,
                         enq_pkg::STATUS_OK);
            if (i == QDEPTH)
            begin
                r.socket = 1;
                r.event_mask = 6'h20;
                r.typed = 1'b1;
                r.want_status = enq_pkg::STATUS_FULL;
            end
            send_cmd(r);
        end
        send_cmd(make_row(enq_pkg::KIND_FETCH, 0, 0, 0, 127, 0, 0, enq_pkg::STATUS_OK));

        // pause until everything has drained
        cmd.valid <= 1'b0;
        while (expected_events.size() != 0)
            @(negedge clk);

        for (int i = 0; i < 30; i++)
        begin
            if (i == 20)
                quiet = 1'b1;
            send_cmd(random_row());
        end
        send_cmd(make_row(enq_pkg::KIND_FETCH, 0, 0, 0, 64, 0, 0, enq_pkg::STATUS_OK));
        send_cmd(make_row(enq_pkg::KIND_FETCH, 0, 0, 0, 64, 0, 0, enq_pkg::STATUS_OK));
        cmd.valid <= 1'b0;

        wait_cycles = 0;
        while (expected_events.size() != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (400) @(negedge clk);
        if (fail_count == 0 && expected_events.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
